[design/rrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue package
// Operation and status codes, state encoding and field types that the
// interfaces and the modules of the record ring queue share.
// ----------------------------------------------------------------------------
package rrq_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_READ   = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_REC_FULL = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_index;
    typedef logic [6:0] t_hlen;
    typedef logic [2:0] t_held;

endpackage

[design/rrq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue channels
// Valid/ready channels for the operation beats and for the result beats.
// ----------------------------------------------------------------------------
interface rrq_in_if;
    logic            valid;
    logic            ready;
    rrq_pkg::t_op    op;
    rrq_pkg::t_byte  data_in;
    rrq_pkg::t_index byte_index;

    modport source (output valid, output op, output data_in, output byte_index, input ready);
    modport sink (input valid, input op, input data_in, input byte_index, output ready);
endinterface

interface rrq_out_if;
    logic             valid;
    logic             ready;
    rrq_pkg::t_status status;
    rrq_pkg::t_byte   read_data;
    rrq_pkg::t_hlen   head_length;
    rrq_pkg::t_held   records_held;

    modport source (output valid, output status, output read_data, output head_length,
                    output records_held, input ready);
    modport sink (input valid, input status, input read_data, input head_length,
                  input records_held, output ready);
endinterface

[design/rrq_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue memory
// Simple dual-port synchronous memory with one write port and one read port
// whose data is registered when a read is requested.
// ----------------------------------------------------------------------------
module rrq_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/record_ring_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue
// Ring of record slots held in a byte memory, with a small memory of record
// lengths. Bytes are appended to the slot being filled, commit closes it, and
// the oldest record is read byte by byte and then popped.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// i_in    | in  | op, data_in, byte_index
// o_out   | out | status, read_data, head_length, records_held
//
// For each operation the beat is accepted and the memories are accessed, then
// the registered read data is combined into the result.
// After reset the byte memory is cleared, during which no beat is accepted.
// A result waiting on o_out holds the block in its finish step.
// ----------------------------------------------------------------------------
module record_ring_queue #(
    parameter int SLOTS        = 4,
    parameter int RECORD_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrq_in_if.sink    i_in,
    rrq_out_if.source o_out
);

    localparam int DEPTH = SLOTS * RECORD_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(RECORD_BYTES + 1);
    localparam int CW    = $clog2(SLOTS + 1);

    rrq_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [SW-1:0]    r_fill_slot, n_fill_slot;
    logic [SW-1:0]    r_head_slot, n_head_slot;
    logic [CW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_fill_len, n_fill_len;
    logic [LW-1:0]    r_head_len, n_head_len;
    rrq_pkg::t_op     r_op, n_op;
    rrq_pkg::t_status r_status, n_status;
    logic             r_idx_ok, n_idx_ok;
    logic             r_out_valid, n_out_valid;
    rrq_pkg::t_status r_out_status, n_out_status;
    rrq_pkg::t_byte   r_out_rdata, n_out_rdata;
    rrq_pkg::t_hlen   r_out_hlen, n_out_hlen;
    rrq_pkg::t_held   r_out_held, n_out_held;

    logic             accept;
    logic             can_load;
    logic             q_full;
    logic             q_empty;
    rrq_pkg::t_status status;
    logic [SW-1:0]    fill_next;
    logic [SW-1:0]    head_next;
    logic [LW-1:0]    done_hlen;

    logic             byte_we;
    logic [AW-1:0]    byte_waddr;
    rrq_pkg::t_byte   byte_wdata;
    logic             byte_re;
    logic [AW-1:0]    byte_raddr;
    rrq_pkg::t_byte   byte_q;
    logic             len_we;
    logic             len_re;
    logic [LW-1:0]    len_q;

    assign i_in.ready = (r_state == rrq_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign can_load   = !r_out_valid || o_out.ready;
    assign q_full     = (r_count == CW'(SLOTS));
    assign q_empty    = (r_count == '0);
    assign fill_next  = (r_fill_slot == SW'(SLOTS - 1)) ? '0 : r_fill_slot + 1'b1;
    assign head_next  = (r_head_slot == SW'(SLOTS - 1)) ? '0 : r_head_slot + 1'b1;

    always_comb begin
        status = rrq_pkg::ST_OK;
        unique case (i_in.op) inside
            rrq_pkg::OP_WRITE: begin
                if (q_full) begin
                    status = rrq_pkg::ST_FULL;
                end else if (r_fill_len == LW'(RECORD_BYTES)) begin
                    status = rrq_pkg::ST_REC_FULL;
                end
            end
            rrq_pkg::OP_COMMIT: begin
                if (q_full) begin
                    status = rrq_pkg::ST_FULL;
                end
            end
            rrq_pkg::OP_READ, rrq_pkg::OP_POP: begin
                if (q_empty) begin
                    status = rrq_pkg::ST_EMPTY;
                end
            end
            default: status = rrq_pkg::ST_OK;
        endcase
    end

    always_comb begin
        if (r_state == rrq_pkg::S_CLEAR) begin
            byte_we    = 1'b1;
            byte_waddr = r_clr_addr;
            byte_wdata = '0;
        end else begin
            byte_we    = accept && (i_in.op == rrq_pkg::OP_WRITE) && (status == rrq_pkg::ST_OK);
            byte_waddr = AW'(AW'(r_fill_slot) * AW'(RECORD_BYTES)) + AW'(r_fill_len);
            byte_wdata = i_in.data_in;
        end
    end

    assign byte_re    = accept && (i_in.op == rrq_pkg::OP_READ);
    assign byte_raddr = AW'(AW'(r_head_slot) * AW'(RECORD_BYTES)) + AW'(i_in.byte_index);
    assign len_we     = accept && (i_in.op == rrq_pkg::OP_COMMIT) && (status == rrq_pkg::ST_OK);
    assign len_re     = accept && (i_in.op == rrq_pkg::OP_POP);

    rrq_mem #(
        .WIDTH ($bits(rrq_pkg::t_byte)),
        .DEPTH (DEPTH)
    ) u_byte_mem (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_q)
    );

    rrq_mem #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_len_mem (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_fill_slot),
        .i_wdata (r_fill_len),
        .i_re    (len_re),
        .i_raddr (head_next),
        .o_rdata (len_q)
    );

    always_comb begin
        if (q_empty) begin
            done_hlen = '0;
        end else if (r_op == rrq_pkg::OP_POP && r_status == rrq_pkg::ST_OK) begin
            done_hlen = len_q;
        end else begin
            done_hlen = r_head_len;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_fill_slot  = r_fill_slot;
        n_head_slot  = r_head_slot;
        n_count      = r_count;
        n_fill_len   = r_fill_len;
        n_head_len   = r_head_len;
        n_op         = r_op;
        n_status     = r_status;
        n_idx_ok     = r_idx_ok;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_rdata  = r_out_rdata;
        n_out_hlen   = r_out_hlen;
        n_out_held   = r_out_held;
        unique case (r_state)
            rrq_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = rrq_pkg::S_IDLE;
                end
            end
            rrq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state  = rrq_pkg::S_DONE;
                    n_op     = i_in.op;
                    n_status = status;
                    n_idx_ok = (32'(i_in.byte_index) < RECORD_BYTES);
                    if (status == rrq_pkg::ST_OK) begin
                        case (i_in.op)
                            rrq_pkg::OP_WRITE: n_fill_len = r_fill_len + 1'b1;
                            rrq_pkg::OP_COMMIT: begin
                                n_fill_slot = fill_next;
                                n_count     = r_count + 1'b1;
                                n_fill_len  = '0;
                                if (q_empty) begin
                                    n_head_len = r_fill_len;
                                end
                            end
                            rrq_pkg::OP_POP: begin
                                n_head_slot = head_next;
                                n_count     = r_count - 1'b1;
                            end
                            default: n_fill_len = r_fill_len;
                        endcase
                    end
                end
            end
            rrq_pkg::S_DONE: begin
                if (can_load) begin
                    n_state      = rrq_pkg::S_IDLE;
                    n_head_len   = done_hlen;
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rdata  = (r_op == rrq_pkg::OP_READ && r_status == rrq_pkg::ST_OK
                                    && r_idx_ok) ? byte_q : '0;
                    n_out_hlen   = rrq_pkg::t_hlen'(done_hlen);
                    n_out_held   = rrq_pkg::t_held'(r_count);
                end
            end
            default: n_state = rrq_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrq_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_fill_slot <= '0;
            r_head_slot <= '0;
            r_count     <= '0;
            r_fill_len  <= '0;
            r_head_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_fill_slot <= n_fill_slot;
            r_head_slot <= n_head_slot;
            r_count     <= n_count;
            r_fill_len  <= n_fill_len;
            r_head_len  <= n_head_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_idx_ok     <= n_idx_ok;
        r_out_status <= n_out_status;
        r_out_rdata  <= n_out_rdata;
        r_out_hlen   <= n_out_hlen;
        r_out_held   <= n_out_held;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.read_data    = r_out_rdata;
    assign o_out.head_length  = r_out_hlen;
    assign o_out.records_held = r_out_held;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("Committed record count exceeds the number of slots.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_len <= LW'(RECORD_BYTES))
        else $error("Fill length exceeds the slot capacity.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == rrq_pkg::S_DONE))
        else $error("Accepted beat did not move the block to its finish step.");

    a_empty_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == rrq_pkg::ST_EMPTY) |-> (o_out.read_data == '0))
        else $error("Empty status carries non-zero read data.");

endmodule

[dv/rrq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue result checker
// Watches the operation and result channels of the record ring queue. Every
// accepted operation beat is applied to a local copy of the byte store, the
// slot lengths and the ring pointers, and the result it should give is
// queued. Every accepted result beat is compared field by field with the
// oldest queued result. Failures, results still owed and status counts are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module rrq_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rrq_in_if    mon_in,
    rrq_out_if   mon_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_hits,
    output int   o_rec_full_hits,
    output int   o_empty_hits
);

    localparam int SLOTS        = 4;
    localparam int RECORD_BYTES = 64;

    typedef struct packed {
        rrq_pkg::t_status status;
        rrq_pkg::t_byte   read_data;
        rrq_pkg::t_hlen   head_length;
        rrq_pkg::t_held   records_held;
    } t_queue_result;

    rrq_pkg::t_byte byte_store [SLOTS*RECORD_BYTES];
    int             slot_len [SLOTS];
    int             fill_slot;
    int             head_slot;
    int             held;
    t_queue_result  owed_results [$];
    int             fail_total;
    int             checked_total;
    int             full_total;
    int             rec_full_total;
    int             empty_total;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_total++;
    endtask

    function automatic t_queue_result apply_queue_op(input rrq_pkg::t_op op,
                                                     input rrq_pkg::t_byte din,
                                                     input rrq_pkg::t_index ix);
        t_queue_result r;
        int            len;
        r.status    = rrq_pkg::ST_OK;
        r.read_data = '0;
        len         = slot_len[fill_slot];
        case (op)
            rrq_pkg::OP_WRITE: begin
                if (held >= SLOTS) begin
                    r.status = rrq_pkg::ST_FULL;
                end else if (len >= RECORD_BYTES) begin
                    r.status = rrq_pkg::ST_REC_FULL;
                end else begin
                    byte_store[fill_slot*RECORD_BYTES + len] = din;
                    slot_len[fill_slot] = len + 1;
                end
            end
            rrq_pkg::OP_COMMIT: begin
                if (held >= SLOTS) begin
                    r.status = rrq_pkg::ST_FULL;
                end else begin
                    fill_slot = (fill_slot + 1) % SLOTS;
                    held++;
                end
            end
            rrq_pkg::OP_READ: begin
                if (held == 0) begin
                    r.status = rrq_pkg::ST_EMPTY;
                end else if (int'(ix) < RECORD_BYTES) begin
                    r.read_data = byte_store[head_slot*RECORD_BYTES + int'(ix)];
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = rrq_pkg::ST_EMPTY;
                end else begin
                    slot_len[head_slot] = 0;
                    head_slot = (head_slot + 1) % SLOTS;
                    held--;
                end
            end
        endcase
        r.head_length  = (held != 0) ? rrq_pkg::t_hlen'(slot_len[head_slot]) : '0;
        r.records_held = rrq_pkg::t_held'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            foreach (byte_store[i]) byte_store[i] = '0;
            foreach (slot_len[i]) slot_len[i] = 0;
            fill_slot = 0;
            head_slot = 0;
            held      = 0;
            owed_results.delete();
        end else begin
            if (mon_out.valid === 1'b1 && mon_out.ready === 1'b1) begin
                got.status       = mon_out.status;
                got.read_data    = mon_out.read_data;
                got.head_length  = mon_out.head_length;
                got.records_held = mon_out.records_held;
                checked_total++;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result beat with none expected (status %0d)",
                                              got.status));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  got.status, want.status));
                    end
                    if (got.read_data !== want.read_data) begin
                        report_mismatch($sformatf("read_data got %0d, expected %0d",
                                                  got.read_data, want.read_data));
                    end
                    if (got.head_length !== want.head_length) begin
                        report_mismatch($sformatf("head_length got %0d, expected %0d",
                                                  got.head_length, want.head_length));
                    end
                    if (got.records_held !== want.records_held) begin
                        report_mismatch($sformatf("records_held got %0d, expected %0d",
                                                  got.records_held, want.records_held));
                    end
                end
            end
            if (mon_in.valid === 1'b1 && mon_in.ready === 1'b1) begin
                want = apply_queue_op(mon_in.op, mon_in.data_in, mon_in.byte_index);
                case (want.status)
                    rrq_pkg::ST_FULL:     full_total++;
                    rrq_pkg::ST_REC_FULL: rec_full_total++;
                    rrq_pkg::ST_EMPTY:    empty_total++;
                    default:              ;
                endcase
                owed_results.push_back(want);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= owed_results.size();
        o_checked       <= checked_total;
        o_full_hits     <= full_total;
        o_rec_full_hits <= rec_full_total;
        o_empty_hits    <= empty_total;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring queue testbench
// Drives operation beats into the record ring queue in bursts with random
// gaps while the result side stalls on its own pattern. A short directed
// sequence covers empty, full and zero-length records; a random part then
// fills records of mixed lengths, reads and pops them, and mixes in noise.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET = 1000;

    logic i_clk;
    logic i_rst_n;

    rrq_in_if  op_ch ();
    rrq_out_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int rec_full_hits;
    int empty_hits;
    int ops_sent [4];
    int beats_sent;
    int burst_left;

    record_ring_queue #(
        .SLOTS        (4),
        .RECORD_BYTES (64)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    rrq_result_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .mon_in          (op_ch),
        .mon_out         (res_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_hits     (full_hits),
        .o_rec_full_hits (rec_full_hits),
        .o_empty_hits    (empty_hits)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    task automatic send_op(input rrq_pkg::t_op op, input rrq_pkg::t_byte din,
                           input rrq_pkg::t_index ix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
            gap = $urandom_range(1, 6);
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        op_ch.valid      <= 1'b1;
        op_ch.op         <= op;
        op_ch.data_in    <= din;
        op_ch.byte_index <= ix;
        @(posedge i_clk);
        while (op_ch.ready !== 1'b1) @(posedge i_clk);
        ops_sent[op]++;
        beats_sent++;
    endtask

    task automatic drain_results();
        op_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic fill_record();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(62, 68);
        end else begin
            n = $urandom_range(0, 8);
        end
        repeat (n) begin
            send_op(rrq_pkg::OP_WRITE, rrq_pkg::t_byte'($urandom_range(0, 255)),
                    rrq_pkg::t_index'($urandom));
        end
        send_op(rrq_pkg::OP_COMMIT, rrq_pkg::t_byte'($urandom), rrq_pkg::t_index'($urandom));
    endtask

    task automatic read_head();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                send_op(rrq_pkg::OP_READ, rrq_pkg::t_byte'($urandom),
                        rrq_pkg::t_index'($urandom_range(0, 63)));
            end else begin
                send_op(rrq_pkg::OP_READ, rrq_pkg::t_byte'($urandom),
                        rrq_pkg::t_index'($urandom_range(0, 10)));
            end
        end
    endtask

    initial begin
        int kind;
        op_ch.valid      <= 1'b0;
        op_ch.op         <= rrq_pkg::OP_WRITE;
        op_ch.data_in    <= '0;
        op_ch.byte_index <= '0;
        i_rst_n          <= 1'b0;
        beats_sent = 0;
        burst_left = 0;
        foreach (ops_sent[i]) ops_sent[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue, a zero-length record, fill to full, then drain.
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd63);
        send_op(rrq_pkg::OP_POP,    8'h00, 6'd0);
        send_op(rrq_pkg::OP_COMMIT, 8'hFF, 6'd63);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd0);
        send_op(rrq_pkg::OP_WRITE,  8'h00, 6'd0);
        send_op(rrq_pkg::OP_WRITE,  8'hFF, 6'd63);
        send_op(rrq_pkg::OP_WRITE,  8'hA5, 6'd21);
        send_op(rrq_pkg::OP_COMMIT, 8'h00, 6'd0);
        send_op(rrq_pkg::OP_COMMIT, 8'h00, 6'd0);
        send_op(rrq_pkg::OP_WRITE,  8'h5A, 6'd42);
        send_op(rrq_pkg::OP_COMMIT, 8'h00, 6'd0);
        send_op(rrq_pkg::OP_WRITE,  8'h3C, 6'd0);
        send_op(rrq_pkg::OP_COMMIT, 8'h00, 6'd0);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd63);
        send_op(rrq_pkg::OP_POP,    8'h00, 6'd0);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd0);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd1);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd2);
        send_op(rrq_pkg::OP_READ,   8'h00, 6'd3);
        send_op(rrq_pkg::OP_POP,    8'h00, 6'd0);
        send_op(rrq_pkg::OP_POP,    8'h00, 6'd0);
        send_op(rrq_pkg::OP_POP,    8'h00, 6'd0);
        send_op(rrq_pkg::OP_POP,    8'hFF, 6'd63);
        send_op(rrq_pkg::OP_READ,   8'hFF, 6'd63);
        drain_results();

        while (beats_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                fill_record();
            end else if (kind < 65) begin
                read_head();
            end else if (kind < 75) begin
                send_op(rrq_pkg::OP_POP, rrq_pkg::t_byte'($urandom),
                        rrq_pkg::t_index'($urandom));
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 5)) begin
                    send_op(rrq_pkg::OP_POP, rrq_pkg::t_byte'($urandom),
                            rrq_pkg::t_index'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_op(rrq_pkg::t_op'($urandom_range(0, 3)),
                            rrq_pkg::t_byte'($urandom_range(0, 255)),
                            rrq_pkg::t_index'($urandom_range(0, 63)));
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d beats: %0d writes, %0d commits, %0d reads, %0d pops.",
                 beats_sent, ops_sent[rrq_pkg::OP_WRITE], ops_sent[rrq_pkg::OP_COMMIT],
                 ops_sent[rrq_pkg::OP_READ], ops_sent[rrq_pkg::OP_POP]);
        $display("Checked %0d results; queue full %0d, record full %0d, queue empty %0d.",
                 checked, full_hits, rec_full_hits, empty_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int cyc;
        int stall_left;
        cyc        = 0;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if ((cyc / 300) % 3 == 0) begin
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 6);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Run timed out with %0d results outstanding.", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[record_ring_queue.f]
design/rrq_pkg.sv
design/rrq_if.sv
design/rrq_mem.sv
design/record_ring_queue.sv
dv/rrq_result_checker.sv
dv/testbench.sv
